// ----- sv/szms_pkg.sv -----
// ----------------------------------------------------------------------------
// String zone map statistics package
// Shared widths, command and verdict codes, and the UTF-8 checker status.
// ----------------------------------------------------------------------------
package szms_pkg;

   localparam int PREFIX_BYTES_DEF = 8;
   localparam int PREFIX_W         = 64;
   localparam int LEN_W            = 32;

   // cmd codes
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // compare_op codes
   localparam logic [1:0] OP_EQ = 2'd0;
   localparam logic [1:0] OP_NE = 2'd1;
   localparam logic [1:0] OP_GT = 2'd2;
   localparam logic [1:0] OP_LT = 2'd3;

   // prune_verdict codes
   localparam logic [1:0] VERDICT_NONE  = 2'd0;
   localparam logic [1:0] VERDICT_FALSE = 2'd1;
   localparam logic [1:0] VERDICT_TRUE  = 2'd2;

   // UTF-8 lead byte classes that narrow the next continuation byte
   localparam logic [2:0] LEAD_ANY = 3'd0;
   localparam logic [2:0] LEAD_E0  = 3'd1;
   localparam logic [2:0] LEAD_ED  = 3'd2;
   localparam logic [2:0] LEAD_F0  = 3'd3;
   localparam logic [2:0] LEAD_F4  = 3'd4;

   // register byte addresses
   localparam logic [1:0] ADDR_IS_VARCHAR = 2'd0;

   // UTF-8 status of the current string, including the byte being fed
   typedef struct packed {
      logic pending;     // inside a multi-byte sequence
      logic invalid;
      logic non_ascii;
   } utf8_status_type;

endpackage

// ----- sv/szms_utf8.sv -----
// ----------------------------------------------------------------------------
// UTF-8 checker
// Strict UTF-8 validation of one string, one byte per beat.
// ----------------------------------------------------------------------------
module szms_utf8 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      feed,       // byte present on this beat
   input  logic                      clear,      // string ends on this beat
   input  logic [7:0]                data_byte,
   output szms_pkg::utf8_status_type status      // status after this byte
);

   logic [1:0] pending_ff,   pending_in;
   logic [2:0] lead_ff,      lead_in;
   logic       non_ascii_ff, non_ascii_in;
   logic       invalid_ff,   invalid_in;
   logic [7:0] lo;
   logic [7:0] hi;

   always_comb begin
      pending_in   = pending_ff;
      lead_in      = lead_ff;
      non_ascii_in = non_ascii_ff;
      invalid_in   = invalid_ff;
      lo           = 8'h80;
      hi           = 8'hBF;
      case (lead_ff)
         szms_pkg::LEAD_E0: lo = 8'hA0;
         szms_pkg::LEAD_ED: hi = 8'h9F;
         szms_pkg::LEAD_F0: lo = 8'h90;
         szms_pkg::LEAD_F4: hi = 8'h8F;
         default: ;
      endcase
      if (feed) begin
         if (pending_ff == 2'd0) begin
            if (data_byte[7]) begin
               non_ascii_in = 1'b1;
               case (data_byte) inside
                  [8'hC2:8'hDF]: begin
                     pending_in = 2'd1;
                     lead_in    = szms_pkg::LEAD_ANY;
                  end
                  8'hE0: begin
                     pending_in = 2'd2;
                     lead_in    = szms_pkg::LEAD_E0;
                  end
                  8'hED: begin
                     pending_in = 2'd2;
                     lead_in    = szms_pkg::LEAD_ED;
                  end
                  [8'hE1:8'hEF]: begin
                     pending_in = 2'd2;
                     lead_in    = szms_pkg::LEAD_ANY;
                  end
                  8'hF0: begin
                     pending_in = 2'd3;
                     lead_in    = szms_pkg::LEAD_F0;
                  end
                  [8'hF1:8'hF3]: begin
                     pending_in = 2'd3;
                     lead_in    = szms_pkg::LEAD_ANY;
                  end
                  8'hF4: begin
                     pending_in = 2'd3;
                     lead_in    = szms_pkg::LEAD_F4;
                  end
                  default: invalid_in = 1'b1;
               endcase
            end
         end else begin
            if (data_byte < lo || data_byte > hi) begin
               invalid_in = 1'b1;
               pending_in = 2'd0;
            end else begin
               pending_in = pending_ff - 2'd1;
            end
            lead_in = szms_pkg::LEAD_ANY;
         end
      end
   end

   assign status.pending   = (pending_in != 2'd0);
   assign status.invalid   = invalid_in;
   assign status.non_ascii = non_ascii_in;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pending_ff   <= 2'd0;
         lead_ff      <= szms_pkg::LEAD_ANY;
         non_ascii_ff <= 1'b0;
         invalid_ff   <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         lead_ff      <= lead_in;
         non_ascii_ff <= non_ascii_in;
         invalid_ff   <= invalid_in;
      end
   end

endmodule

// ----- sv/string_zonemap_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// String zone map statistics unit
// Running min/max string prefixes, max length and UTF-8 analysis, with
// prune verdicts for zone map queries; strings stream in one byte per beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                  payload
//  req      in   req_tvalid/req_tready      tdata: data_byte, has_byte
//                                           tuser: cmd, compare_op; tlast
//  rsp      out  rsp_tvalid/rsp_tready      tdata: verdict and statistics
//  csr      in   APB write/read, pready=1   is_varchar at byte address 0
//
// One byte beat per cycle, sustained. A beat is registered on accept and
// worked from that register into the state and, on a last beat, into
// the result register; rsp_tvalid rises as the result register loads.
// A full result register stalls only last beats; reset is synchronous and
// restores the statistics at once, with no clearing pass.
module string_zonemap_statistics_unit #(
   parameter int PREFIX_BYTES = szms_pkg::PREFIX_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [7:0] data_byte, [8] has_byte, [15:9] zero
   input  logic [2:0]   req_tuser,   // [0] cmd, [2:1] compare_op
   input  logic         req_tlast,   // last_byte
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,   // [1:0] prune_verdict, [65:2] min_prefix_out,
                                     // [129:66] max_prefix_out, [161:130] max_length_out,
                                     // [162] unicode_seen, [163] invalid_utf8,
                                     // [167:164] zero
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int PW = szms_pkg::PREFIX_W;
   localparam int LW = szms_pkg::LEN_W;

   // byte i of the prefix is covered when i < n
   function automatic logic [PW-1:0] top_mask(input logic [3:0] n);
      logic [PW-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         m[PW-1-8*i -: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // ---------------- configuration ----------------
   logic is_varchar_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == szms_pkg::ADDR_IS_VARCHAR) ?
                       {31'd0, is_varchar_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_varchar_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == szms_pkg::ADDR_IS_VARCHAR) begin
         is_varchar_ff <= csr_pwdata[0];
      end
   end

   // ---------------- input register ----------------
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_has_ff;
   logic       s1_last_ff;
   logic       s1_cmd_ff;
   logic [1:0] s1_op_ff;
   logic       out_free;
   logic       advance;
   logic       out_load;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign advance    = s1_valid_ff && (!s1_last_ff || out_free);
   assign out_load   = advance && s1_last_ff;
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata[7:0];
         s1_has_ff  <= req_tdata[8];
         s1_last_ff <= req_tlast;
         s1_cmd_ff  <= req_tuser[0];
         s1_op_ff   <= req_tuser[2:1];
      end
   end

   // ---------------- current string ----------------
   logic [PW-1:0] cur_prefix_ff, cur_prefix_in;
   logic [LW-1:0] cur_len_ff,    cur_len_in;
   szms_pkg::utf8_status_type utf8_st;

   szms_utf8 u_utf8 (
      .clock     (clock),
      .reset     (reset),
      .feed      (advance && s1_has_ff),
      .clear     (out_load),
      .data_byte (s1_byte_ff),
      .status    (utf8_st)
   );

   always_comb begin
      cur_prefix_in = cur_prefix_ff;
      cur_len_in    = cur_len_ff;
      if (s1_has_ff) begin
         if (cur_len_ff < LW'(PREFIX_BYTES)) begin
            cur_prefix_in = cur_prefix_ff |
                            ({s1_byte_ff, {(PW-8){1'b0}}} >> {cur_len_ff[2:0], 3'b000});
         end
         if (cur_len_ff != '1) begin
            cur_len_in = cur_len_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || out_load) begin
         cur_prefix_ff <= '0;
         cur_len_ff    <= '0;
      end else if (advance) begin
         cur_prefix_ff <= cur_prefix_in;
         cur_len_ff    <= cur_len_in;
      end
   end

   // ---------------- statistics and verdict ----------------
   logic [PW-1:0] min_ff, min_in;
   logic [PW-1:0] max_ff, max_in;
   logic [LW-1:0] max_len_ff, max_len_in;
   logic          unicode_ff, unicode_in;
   logic          invalid;
   logic [1:0]    verdict;
   logic [3:0]    q_bytes;
   logic [PW-1:0] q_mask;
   logic          below_min;
   logic          above_max;

   always_comb begin
      min_in     = min_ff;
      max_in     = max_ff;
      max_len_in = max_len_ff;
      unicode_in = unicode_ff;
      invalid    = 1'b0;
      verdict    = szms_pkg::VERDICT_NONE;
      q_bytes    = (cur_len_in < LW'(PREFIX_BYTES)) ? cur_len_in[3:0] : 4'(PREFIX_BYTES);
      q_mask     = top_mask(q_bytes);
      below_min  = (cur_prefix_in & q_mask) < (min_ff & q_mask);
      above_max  = (cur_prefix_in & q_mask) > (max_ff & q_mask);
      if (s1_cmd_ff == szms_pkg::CMD_UPDATE) begin
         if (cur_prefix_in < min_ff) min_in = cur_prefix_in;
         if (cur_prefix_in > max_ff) max_in = cur_prefix_in;
         if (cur_len_in > max_len_ff) max_len_in = cur_len_in;
         if (is_varchar_ff && !unicode_ff) begin
            if (utf8_st.invalid || utf8_st.pending) invalid = 1'b1;
            else if (utf8_st.non_ascii) unicode_in = 1'b1;
         end
      end else begin
         case (s1_op_ff)
            szms_pkg::OP_EQ:
               verdict = (below_min || above_max) ? szms_pkg::VERDICT_FALSE
                                                  : szms_pkg::VERDICT_NONE;
            szms_pkg::OP_NE:
               verdict = (below_min || above_max) ? szms_pkg::VERDICT_TRUE
                                                  : szms_pkg::VERDICT_NONE;
            szms_pkg::OP_GT:
               verdict = above_max ? szms_pkg::VERDICT_FALSE : szms_pkg::VERDICT_NONE;
            default:
               verdict = below_min ? szms_pkg::VERDICT_FALSE : szms_pkg::VERDICT_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= top_mask(4'(PREFIX_BYTES));
         max_ff     <= '0;
         max_len_ff <= '0;
         unicode_ff <= 1'b0;
      end else if (out_load) begin
         min_ff     <= min_in;
         max_ff     <= max_in;
         max_len_ff <= max_len_in;
         unicode_ff <= unicode_in;
      end
   end

   // ---------------- result register ----------------
   logic          rsp_valid_ff;
   logic [1:0]    rsp_verdict_ff;
   logic [PW-1:0] rsp_min_ff;
   logic [PW-1:0] rsp_max_ff;
   logic [LW-1:0] rsp_len_ff;
   logic          rsp_unicode_ff;
   logic          rsp_invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_verdict_ff <= verdict;
         rsp_min_ff     <= min_in;
         rsp_max_ff     <= max_in;
         rsp_len_ff     <= max_len_in;
         rsp_unicode_ff <= unicode_in;
         rsp_invalid_ff <= invalid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_invalid_ff, rsp_unicode_ff, rsp_len_ff,
                        rsp_max_ff, rsp_min_ff, rsp_verdict_ff};

`ifndef SYNTHESIS
   // a query never moves the statistics
   a_query_keeps_stats: assert property (@(posedge clock) disable iff (reset)
      out_load && s1_cmd_ff == szms_pkg::CMD_QUERY |=> $stable(min_ff) && $stable(max_ff)
                                                        && $stable(max_len_ff))
      else $error("query beat changed the statistics");

   // an empty current string has an empty prefix
   a_empty_prefix: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff == '0 |-> cur_prefix_ff == '0)
      else $error("prefix bits set with zero length");

   // a result flagged invalid comes from an update and carries no verdict
   a_invalid_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_invalid_ff |-> rsp_verdict_ff == szms_pkg::VERDICT_NONE)
      else $error("invalid_utf8 set on a query result");
`endif

endmodule

// ----- tb/szms_zone_checker.sv -----
// ----------------------------------------------------------------------------
// String zone map statistics checker
// Watches the request, response and register ports, keeps its own copy of the
// statistics and UTF-8 state, predicts each result and compares it field by
// field with the response beats in order.
// ----------------------------------------------------------------------------
module szms_zone_checker
   import szms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [15:0]   req_tdata,   // [7:0] data_byte, [8] has_byte
   input  logic [2:0]    req_tuser,   // [0] cmd, [2:1] compare_op
   input  logic          req_tlast,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [167:0]  rsp_tdata,   // verdict, min, max, max length, unicode, invalid
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [1:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   input  logic          csr_pready,
   output int unsigned   fail_count,
   output int unsigned   outstanding
);

   typedef struct packed {
      logic [1:0]  verdict;
      logic [63:0] min_prefix;
      logic [63:0] max_prefix;
      logic [31:0] max_length;
      logic        unicode;
      logic        invalid;
   } zone_result_t;

   zone_result_t expected_q[$];
   int unsigned  mismatches = 0;

   // column statistics
   logic        varchar_en;
   logic [63:0] stat_min;
   logic [63:0] stat_max;
   logic [31:0] stat_maxlen;
   logic        stat_unicode;
   // string in flight
   logic [63:0] str_prefix;
   logic [31:0] str_len;
   logic [1:0]  seq_left;
   logic [2:0]  seq_lead;
   logic        str_non_ascii;
   logic        str_bad;

   task clear_string();
      str_prefix    = '0;
      str_len       = '0;
      seq_left      = '0;
      seq_lead      = LEAD_ANY;
      str_non_ascii = 1'b0;
      str_bad       = 1'b0;
   endtask

   task feed_utf8(input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      if (seq_left == 2'd0) begin
         if (b < 8'h80) return;
         str_non_ascii = 1'b1;
         if (b >= 8'hC2 && b <= 8'hDF) begin
            seq_left = 2'd1; seq_lead = LEAD_ANY;
         end else if (b == 8'hE0) begin
            seq_left = 2'd2; seq_lead = LEAD_E0;
         end else if (b == 8'hED) begin
            seq_left = 2'd2; seq_lead = LEAD_ED;
         end else if (b >= 8'hE1 && b <= 8'hEF) begin
            seq_left = 2'd2; seq_lead = LEAD_ANY;
         end else if (b == 8'hF0) begin
            seq_left = 2'd3; seq_lead = LEAD_F0;
         end else if (b >= 8'hF1 && b <= 8'hF3) begin
            seq_left = 2'd3; seq_lead = LEAD_ANY;
         end else if (b == 8'hF4) begin
            seq_left = 2'd3; seq_lead = LEAD_F4;
         end else begin
            str_bad = 1'b1;
         end
      end else begin
         lo = 8'h80;
         hi = 8'hBF;
         // only the first continuation after these leads is narrowed
         case (seq_lead)
            LEAD_E0: lo = 8'hA0;
            LEAD_ED: hi = 8'h9F;
            LEAD_F0: lo = 8'h90;
            LEAD_F4: hi = 8'h8F;
            default: ;
         endcase
         if (b < lo || b > hi) begin
            str_bad  = 1'b1;
            seq_left = 2'd0;
         end else begin
            seq_left = seq_left - 2'd1;
         end
         seq_lead = LEAD_ANY;
      end
   endtask

   task absorb_beat(input logic cmd, input logic [7:0] data, input logic has,
                    input logic last, input logic [1:0] op);
      zone_result_t r;
      int unsigned  n;
      logic [63:0]  mask;
      logic [63:0]  q;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic         below;
      logic         above;
      if (has) begin
         if (str_len < PREFIX_BYTES_DEF)
            str_prefix = str_prefix | ({56'd0, data} << (56 - 8 * str_len));
         if (str_len != 32'hFFFF_FFFF) str_len = str_len + 32'd1;
         feed_utf8(data);
      end
      if (!last) return;
      r = '0;
      if (cmd == CMD_UPDATE) begin
         if (str_prefix < stat_min) stat_min = str_prefix;
         if (str_prefix > stat_max) stat_max = str_prefix;
         if (str_len > stat_maxlen) stat_maxlen = str_len;
         if (varchar_en && !stat_unicode) begin
            if (str_bad || seq_left != 2'd0) r.invalid = 1'b1;
            else if (str_non_ascii) stat_unicode = 1'b1;
         end
         r.verdict = VERDICT_NONE;
      end else begin
         n     = (str_len < PREFIX_BYTES_DEF) ? str_len : PREFIX_BYTES_DEF;
         mask  = (n == 0) ? 64'd0 : (~64'd0 << (64 - 8 * n));
         q     = str_prefix & mask;
         lo    = stat_min & mask;
         hi    = stat_max & mask;
         below = q < lo;
         above = q > hi;
         case (op)
            OP_EQ:   r.verdict = (!below && !above) ? VERDICT_NONE : VERDICT_FALSE;
            OP_NE:   r.verdict = (below || above) ? VERDICT_TRUE : VERDICT_NONE;
            OP_GT:   r.verdict = above ? VERDICT_FALSE : VERDICT_NONE;
            default: r.verdict = below ? VERDICT_FALSE : VERDICT_NONE;
         endcase
      end
      r.min_prefix = stat_min;
      r.max_prefix = stat_max;
      r.max_length = stat_maxlen;
      r.unicode    = stat_unicode;
      expected_q.push_back(r);
      clear_string();
   endtask

   task check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      zone_result_t exp_r;
      if (reset) begin
         varchar_en   = 1'b1;
         stat_min     = '1;
         stat_max     = '0;
         stat_maxlen  = '0;
         stat_unicode = 1'b0;
         clear_string();
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ADDR_IS_VARCHAR)
            varchar_en = csr_pwdata[0];
         if (req_tvalid && req_tready)
            absorb_beat(req_tuser[0], req_tdata[7:0], req_tdata[8], req_tlast,
                        req_tuser[2:1]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("result beat with no expectation waiting");
               mismatches++;
            end else begin
               exp_r = expected_q.pop_front();
               check_field("prune_verdict", 64'(exp_r.verdict), 64'(rsp_tdata[1:0]));
               check_field("min_prefix_out", exp_r.min_prefix, rsp_tdata[65:2]);
               check_field("max_prefix_out", exp_r.max_prefix, rsp_tdata[129:66]);
               check_field("max_length_out", 64'(exp_r.max_length), 64'(rsp_tdata[161:130]));
               check_field("unicode_seen", 64'(exp_r.unicode), 64'(rsp_tdata[162]));
               check_field("invalid_utf8", 64'(exp_r.invalid), 64'(rsp_tdata[163]));
            end
         end
      end
      fail_count  <= mismatches;
      outstanding <= expected_q.size();
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// String zone map statistics testbench
// Streams update and query strings into the unit one byte per beat, with
// random gaps and response back-pressure, toggles the varchar register while
// idle, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;
   import szms_pkg::*;

   typedef logic [7:0] octet_q_t[$];

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata   = '0;   // [7:0] data_byte, [8] has_byte, [15:9] zero
   logic [2:0]   req_tuser   = '0;   // [0] cmd, [2:1] compare_op
   logic         req_tlast   = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [167:0] rsp_tdata;          // [1:0] verdict, [65:2] min, [129:66] max,
                                     // [161:130] max length, [162] unicode, [163] invalid
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [1:0]   csr_paddr   = ADDR_IS_VARCHAR;
   logic [31:0]  csr_pwdata  = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int unsigned  fail_count;
   int unsigned  outstanding;
   bit           idle_en     = 1'b1;
   int unsigned  beats_sent  = 0;

   string_zonemap_statistics_unit u_top (.*);

   szms_zone_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("testbench failed");
      $finish;
   end

   always @(posedge clock)
      rsp_tready <= !idle_en || ($urandom_range(99) >= 28);

   task automatic send_beat(input logic cmd, input logic [1:0] op, input logic [7:0] data,
                            input logic has, input logic last);
      while (idle_en && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, has, data};
      req_tuser  <= {op, cmd};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (has || last) beats_sent++;
   endtask

   // the final beat's cmd and op decide; mixed scrambles the earlier beats
   task automatic send_string(input logic cmd, input logic [1:0] op, input octet_q_t txt,
                              input bit mixed, input bit empty_last);
      logic       c;
      logic [1:0] o;
      for (int i = 0; i < txt.size(); i++) begin
         if ($urandom_range(15) == 0)
            send_beat(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom), 1'b0, 1'b0);
         c = cmd;
         o = op;
         if (mixed && (empty_last || i != txt.size() - 1)) begin
            c = 1'($urandom_range(1));
            o = 2'($urandom_range(3));
         end
         send_beat(c, o, txt[i], 1'b1, !empty_last && i == txt.size() - 1);
      end
      if (empty_last || txt.size() == 0)
         send_beat(cmd, op, 8'($urandom), 1'b0, 1'b1);
   endtask

   // valid multi-byte sequence; with cut, its tail is dropped
   function automatic void put_valid(ref octet_q_t txt, input bit cut);
      octet_q_t   seq;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] c3;
      c1 = 8'h80 + 8'($urandom_range(63));
      c2 = 8'h80 + 8'($urandom_range(63));
      c3 = 8'h80 + 8'($urandom_range(63));
      case ($urandom_range(6))
         0: seq = '{8'hC2 + 8'($urandom_range(29)), c1};
         1: seq = '{8'hE0, 8'hA0 + 8'($urandom_range(31)), c2};
         2: seq = '{$urandom_range(1) ? 8'hE1 + 8'($urandom_range(11))
                                       : 8'hEE + 8'($urandom_range(1)), c1, c2};
         3: seq = '{8'hED, 8'h80 + 8'($urandom_range(31)), c2};
         4: seq = '{8'hF0, 8'h90 + 8'($urandom_range(47)), c2, c3};
         5: seq = '{8'hF1 + 8'($urandom_range(2)), c1, c2, c3};
         default: seq = '{8'hF4, 8'h80 + 8'($urandom_range(15)), c2, c3};
      endcase
      if (cut)
         repeat ($urandom_range(1, seq.size() - 1)) void'(seq.pop_back());
      foreach (seq[i]) txt.push_back(seq[i]);
   endfunction

   // strict: while the UTF-8 check can fire, a non-ASCII update is always
   // made invalid so the unicode flag stays clear
   task automatic run_phase(input int unsigned target, input bit strict, input bit banded);
      octet_q_t    txt;
      bit          is_update;
      bit          damaged;
      bit          nonascii;
      int unsigned pieces;
      int unsigned len;
      int unsigned b;
      while (beats_sent < target) begin
         txt.delete();
         damaged   = 1'b0;
         nonascii  = 1'b0;
         is_update = $urandom_range(99) < 55;
         if (is_update) begin
            // keep updates in a narrow band so queries can fall outside it
            if (banded) txt.push_back(8'h68 + 8'($urandom_range(11)));
            pieces = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 6);
            repeat (pieces) begin
               case ($urandom_range(3))
                  2: begin
                     put_valid(txt, 1'b0);
                     nonascii = 1'b1;
                  end
                  3: begin
                     damaged = 1'b1;
                     case ($urandom_range(6))
                        0: txt.push_back(8'h80 + 8'($urandom_range(63)));
                        1: begin
                           b = $urandom_range(12);
                           txt.push_back(b < 2 ? 8'hC0 + 8'(b) : 8'hF3 + 8'(b));
                        end
                        2: begin
                           txt.push_back(8'hE0);
                           txt.push_back(8'h80 + 8'($urandom_range(31)));
                        end
                        3: begin
                           txt.push_back(8'hED);
                           txt.push_back(8'hA0 + 8'($urandom_range(31)));
                        end
                        4: begin
                           txt.push_back(8'hF0);
                           txt.push_back(8'h80 + 8'($urandom_range(15)));
                        end
                        5: begin
                           txt.push_back(8'hF4);
                           txt.push_back(8'h90 + 8'($urandom_range(47)));
                        end
                        default: begin
                           txt.push_back(8'hC2 + 8'($urandom_range(29)));
                           txt.push_back(8'($urandom_range(127)));
                        end
                     endcase
                  end
                  default: txt.push_back(8'($urandom_range(127)));
               endcase
            end
            if ((strict && nonascii && !damaged) || $urandom_range(7) == 0)
               put_valid(txt, 1'b1);
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
               txt.push_back((i == 0 && $urandom_range(1)) ? 8'h64 + 8'($urandom_range(19))
                                                           : 8'($urandom_range(255)));
         end
         send_string(is_update ? CMD_UPDATE : CMD_QUERY, 2'($urandom_range(3)), txt,
                     $urandom_range(3) == 0, $urandom_range(7) == 0);
      end
   endtask

   // called at a clock edge right after the last accepted beat
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_IS_VARCHAR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      octet_q_t txt;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // queries against untouched statistics, then an empty query
      txt = '{8'h71};
      send_string(CMD_QUERY, OP_EQ, txt, 1'b0, 1'b0);
      send_string(CMD_QUERY, OP_NE, txt, 1'b0, 1'b0);
      send_string(CMD_QUERY, OP_GT, txt, 1'b0, 1'b0);
      send_string(CMD_QUERY, OP_LT, txt, 1'b0, 1'b0);
      txt.delete();
      send_string(CMD_QUERY, OP_NE, txt, 1'b0, 1'b0);
      // bad continuation after E0, surrogate, above U+10FFFF, truncated, bad lead
      txt = '{8'h6D, 8'hE0, 8'h80};
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b0);
      txt = '{8'h6E, 8'hED, 8'hA0, 8'h80};
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b0);
      txt = '{8'h6F, 8'hF4, 8'h90};
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b0);
      txt = '{8'h70, 8'hE2, 8'h82};
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b1);
      txt = '{8'h6C, 8'hFF};
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b0);
      send_beat(CMD_UPDATE, OP_EQ, 8'h00, 1'b0, 1'b0);
      txt = '{8'h6D, 8'h00};
      send_string(CMD_QUERY, OP_EQ, txt, 1'b1, 1'b0);

      run_phase(680, 1'b1, 1'b1);
      wait_idle();
      csr_write(32'd0);
      idle_en <= 1'b0;
      run_phase(1080, 1'b0, 1'b1);
      wait_idle();
      csr_write(32'd1);
      idle_en <= 1'b1;
      run_phase(1480, 1'b1, 1'b1);

      // first valid non-ASCII update latches the unicode flag
      txt = '{8'h6D, 8'hC3, 8'hA9};
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b0);
      run_phase(1780, 1'b0, 1'b1);

      // widest prefixes: all ones and the empty string
      txt.delete();
      repeat (9) txt.push_back(8'hFF);
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b0);
      txt.delete();
      send_string(CMD_UPDATE, OP_EQ, txt, 1'b0, 1'b0);
      run_phase(1950, 1'b0, 1'b0);

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
